// ===== rtl/core/zost_pkg.sv =====
// Package for the z-order sorted table core.
// Holds the shared types, codes and field widths used by the core top level and its cells.
// Depends on nothing.
package zost_pkg;

   localparam int ID_W  = 16;
   localparam int KEY_W = 16;
   localparam int POS_W = 6;

   typedef enum logic [2:0] {
      ACT_ADD     = 3'd0,
      ACT_DEL_ID  = 3'd1,
      ACT_CHG_ID  = 3'd2,
      ACT_DEL_POS = 3'd3,
      ACT_CHG_POS = 3'd4,
      ACT_LOCK    = 3'd5,
      ACT_UNLOCK  = 3'd6,
      ACT_READ    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_QUEUED   = 3'd1,
      STS_NOTFOUND = 3'd2,
      STS_BADPOS   = 3'd3,
      STS_TFULL    = 3'd4,
      STS_QFULL    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_DEL = 2'd1,
      KIND_CHG = 2'd2
   } kind_type;

   // Command broadcast to every cell of the row.
   typedef enum logic [2:0] {
      CH_HOLD      = 3'd0,
      CH_SCAN_INIT = 3'd1,
      CH_SCAN_STEP = 3'd2,
      CH_INSERT    = 3'd3,
      CH_DELETE    = 3'd4
   } chain_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOCK_POS,
      ST_SCAN_INIT,
      ST_SCAN_STEP,
      ST_APPLY,
      ST_INSERT,
      ST_RP_READ,
      ST_RP_EXEC,
      ST_RP_NEXT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } link_type;

   // Scan value: first marked cell seen so far, and whether its key equals the
   // broadcast key.
   typedef struct packed {
      logic found;
      logic eq;
   } scan_type;

   typedef struct packed {
      chain_op_type     op;
      logic             by_pos;
      logic [POS_W-1:0] pos;
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } cell_cmd_type;

   typedef struct packed {
      kind_type         kind;
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } queue_entry_type;

endpackage

// ===== rtl/core/z_order_sorted_table_core.sv =====
// Top level of the z-order sorted table: row of entry cells, deferred queue
// RAM and the action sequencer. Depends on zost_pkg, zost_cell and zost_ram.
//
// Use: one request beat on req_* carries an action (add, delete or change by
// id, delete or change by position, lock, unlock, read) and its operands. Each
// request gives exactly one response beat on rsp_* with a status, the entry
// count, the read id and key (zero unless a read succeeds) and the queue fill.
// Entries live in a row of cells, kept sorted by ascending signed key.
// Deletes and changes use a log-step prefix scan that finds the first matching
// cell: one scan step per cycle across the row.
// A request is taken only while the sequencer is idle; a finished response
// sits in the output register, so the next request is taken while that
// response is stalled. A stalled response holds until the receiver takes it.
// Reset empties the table and the queue and unlocks; entry and queue storage
// is not cleared and needs no clearing pass.
module z_order_sorted_table_core #(
   parameter int TABLE_DEPTH = 64,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [2:0]                             req_action,
   input  logic [zost_pkg::ID_W-1:0]              req_elem_id,
   input  logic [zost_pkg::POS_W-1:0]             req_position,
   input  logic signed [zost_pkg::KEY_W-1:0]      req_z_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [2:0]                             rsp_status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]       rsp_entry_count,
   output logic [zost_pkg::ID_W-1:0]              rsp_out_id,
   output logic signed [zost_pkg::KEY_W-1:0]      rsp_out_z,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       rsp_queued_count
);

   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
   localparam int QAW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int STEPS = $clog2(TABLE_DEPTH);
   localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int CMPW  = (CW > zost_pkg::POS_W) ? CW : zost_pkg::POS_W;
   localparam int RD_N  = (TABLE_DEPTH < (1 << zost_pkg::POS_W)) ?
                          TABLE_DEPTH : (1 << zost_pkg::POS_W);
   localparam int QEW   = $bits(zost_pkg::queue_entry_type);

   // ---------------------------------------------------------------------
   // Control and payload registers
   // ---------------------------------------------------------------------
   zost_pkg::state_type            state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [QCW-1:0]                 tail_ff, tail_in;
   logic [QCW-1:0]                 idx_ff, idx_in;
   logic [SW-1:0]                  step_ff, step_in;
   logic                           lock_ff, lock_in;
   logic                           replay_ff, replay_in;
   zost_pkg::kind_type             op_kind_ff, op_kind_in;
   logic                           by_pos_ff, by_pos_in;
   logic [zost_pkg::ID_W-1:0]      id_ff, id_in;
   logic [zost_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [zost_pkg::POS_W-1:0]     pos_ff, pos_in;
   zost_pkg::status_type           status_ff, status_in;
   logic [zost_pkg::ID_W-1:0]      rid_ff, rid_in;
   logic [zost_pkg::KEY_W-1:0]     rkey_ff, rkey_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   zost_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                  rsp_count_ff, rsp_count_in;
   logic [zost_pkg::ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [zost_pkg::KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [QCW-1:0]                 rsp_qcount_ff, rsp_qcount_in;

   // ---------------------------------------------------------------------
   // Cell row wiring
   // ---------------------------------------------------------------------
   zost_pkg::cell_cmd_type         cmd;
   zost_pkg::chain_op_type         chain_op;
   zost_pkg::link_type             cell_data  [TABLE_DEPTH];
   logic                           cell_le    [TABLE_DEPTH];
   zost_pkg::scan_type             cell_scan  [TABLE_DEPTH];
   logic                           cell_valid [TABLE_DEPTH];
   zost_pkg::scan_type             far_cand   [TABLE_DEPTH][STEPS];

   assign cmd.op     = chain_op;
   assign cmd.by_pos = by_pos_ff;
   assign cmd.pos    = pos_ff;
   assign cmd.id     = id_ff;
   assign cmd.key    = key_ff;

   genvar gi, gk;
   generate
      for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
         zost_pkg::link_type left_data;
         logic               left_le;
         zost_pkg::link_type right_data;

         assign cell_valid[gi] = (CW'(gi) < count_ff);

         // Scan partner at distance 2^step; cells near the head see nothing.
         for (gk = 0; gk < STEPS; gk++) begin : g_far
            if (gi >= (1 << gk)) begin : g_src
               assign far_cand[gi][gk] = cell_scan[gi - (1 << gk)];
            end else begin : g_none
               assign far_cand[gi][gk] = '0;
            end
         end

         if (gi == 0) begin : g_head
            assign left_data = '0;
            assign left_le   = 1'b1;
         end else begin : g_mid
            assign left_data = cell_data[gi-1];
            assign left_le   = cell_le[gi-1];
         end

         if (gi == TABLE_DEPTH - 1) begin : g_tail
            assign right_data = cell_data[gi];
         end else begin : g_body
            assign right_data = cell_data[gi+1];
         end

         zost_cell #(
            .IDX (gi)
         ) u_cell (
            .clock   (clock),
            .cmd     (cmd),
            .valid   (cell_valid[gi]),
            .left    (left_data),
            .left_le (left_le),
            .right   (right_data),
            .far     (far_cand[gi][step_ff]),
            .data    (cell_data[gi]),
            .le      (cell_le[gi]),
            .scan    (cell_scan[gi])
         );
      end
   endgenerate

   // Last cell holds the scan result for the whole row.
   zost_pkg::scan_type row_scan;
   assign row_scan = cell_scan[TABLE_DEPTH-1];

   // Read selector over the addressable positions.
   logic [zost_pkg::ID_W-1:0]  sel_id;
   logic [zost_pkg::KEY_W-1:0] sel_key;

   always_comb begin
      sel_id  = '0;
      sel_key = '0;
      for (int j = 0; j < RD_N; j++) begin
         if (int'(pos_ff) == j) begin
            sel_id  = cell_data[j].id;
            sel_key = cell_data[j].key;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Deferred action queue
   // ---------------------------------------------------------------------
   logic                      q_wr_en;
   zost_pkg::queue_entry_type q_wr_entry;
   logic [QEW-1:0]            q_rd_data;
   zost_pkg::queue_entry_type q_rd_entry;

   assign q_rd_entry = zost_pkg::queue_entry_type'(q_rd_data);

   zost_ram #(
      .WIDTH (QEW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_ff[QAW-1:0]),
      .wr_data (q_wr_entry),
      .rd_addr (idx_ff[QAW-1:0]),
      .rd_data (q_rd_data)
   );

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic                 req_accept;
   logic                 req_pos_ok;
   logic                 table_full;
   logic                 queue_full;
   zost_pkg::state_type  done_state;
   zost_pkg::action_type req_act;

   assign req_stall  = (state_ff != zost_pkg::ST_IDLE);
   assign req_accept = req_valid && (state_ff == zost_pkg::ST_IDLE);
   assign req_pos_ok = (CMPW'(req_position) < CMPW'(count_ff));
   assign table_full = (count_ff == CW'(TABLE_DEPTH));
   assign queue_full = (tail_ff == QCW'(QUEUE_DEPTH));
   assign done_state = replay_ff ? zost_pkg::ST_RP_NEXT : zost_pkg::ST_RESP;
   assign req_act    = zost_pkg::action_type'(req_action);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      tail_in    = tail_ff;
      idx_in     = idx_ff;
      step_in    = step_ff;
      lock_in    = lock_ff;
      replay_in  = replay_ff;
      op_kind_in = op_kind_ff;
      by_pos_in  = by_pos_ff;
      id_in      = id_ff;
      key_in     = key_ff;
      pos_in     = pos_ff;
      status_in  = status_ff;
      rid_in     = rid_ff;
      rkey_in    = rkey_ff;
      chain_op   = zost_pkg::CH_HOLD;
      q_wr_en    = 1'b0;
      q_wr_entry.kind = op_kind_ff;
      q_wr_entry.id   = sel_id;
      q_wr_entry.key  = key_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_qcount_in = rsp_qcount_ff;

      unique case (state_ff)
         zost_pkg::ST_IDLE: begin
            if (req_accept) begin
               id_in     = req_elem_id;
               key_in    = req_z_value;
               pos_in    = req_position;
               status_in = zost_pkg::STS_OK;
               rid_in    = '0;
               rkey_in   = '0;
               replay_in = 1'b0;
               by_pos_in = 1'b0;
               state_in  = zost_pkg::ST_RESP;
               q_wr_entry.id  = req_elem_id;
               q_wr_entry.key = req_z_value;
               unique case (req_act)
                  zost_pkg::ACT_ADD: begin
                     op_kind_in = zost_pkg::KIND_ADD;
                     q_wr_entry.kind = zost_pkg::KIND_ADD;
                     if (lock_ff) begin
                        if (queue_full) begin
                           status_in = zost_pkg::STS_QFULL;
                        end else begin
                           q_wr_en   = 1'b1;
                           tail_in   = tail_ff + QCW'(1);
                           status_in = zost_pkg::STS_QUEUED;
                        end
                     end else if (table_full) begin
                        status_in = zost_pkg::STS_TFULL;
                     end else begin
                        state_in = zost_pkg::ST_INSERT;
                     end
                  end
                  zost_pkg::ACT_DEL_ID, zost_pkg::ACT_CHG_ID: begin
                     op_kind_in = (req_act == zost_pkg::ACT_DEL_ID) ?
                                  zost_pkg::KIND_DEL : zost_pkg::KIND_CHG;
                     q_wr_entry.kind = op_kind_in;
                     if (lock_ff) begin
                        if (queue_full) begin
                           status_in = zost_pkg::STS_QFULL;
                        end else begin
                           q_wr_en   = 1'b1;
                           tail_in   = tail_ff + QCW'(1);
                           status_in = zost_pkg::STS_QUEUED;
                        end
                     end else begin
                        state_in = zost_pkg::ST_SCAN_INIT;
                     end
                  end
                  zost_pkg::ACT_DEL_POS, zost_pkg::ACT_CHG_POS: begin
                     op_kind_in = (req_act == zost_pkg::ACT_DEL_POS) ?
                                  zost_pkg::KIND_DEL : zost_pkg::KIND_CHG;
                     by_pos_in  = 1'b1;
                     if (!req_pos_ok) begin
                        status_in = zost_pkg::STS_BADPOS;
                     end else if (lock_ff) begin
                        if (queue_full) begin
                           status_in = zost_pkg::STS_QFULL;
                        end else begin
                           // turn the position into an id next cycle
                           state_in = zost_pkg::ST_LOCK_POS;
                        end
                     end else begin
                        state_in = zost_pkg::ST_SCAN_INIT;
                     end
                  end
                  zost_pkg::ACT_LOCK: begin
                     lock_in = 1'b1;
                  end
                  zost_pkg::ACT_UNLOCK: begin
                     lock_in   = 1'b0;
                     idx_in    = '0;
                     replay_in = (tail_ff != '0);
                     if (tail_ff != '0) begin
                        state_in = zost_pkg::ST_RP_READ;
                     end
                  end
                  zost_pkg::ACT_READ: begin
                     if (!req_pos_ok) begin
                        status_in = zost_pkg::STS_BADPOS;
                     end else begin
                        state_in = zost_pkg::ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         zost_pkg::ST_READ: begin
            rid_in   = sel_id;
            rkey_in  = sel_key;
            state_in = zost_pkg::ST_RESP;
         end

         zost_pkg::ST_LOCK_POS: begin
            q_wr_en   = 1'b1;
            tail_in   = tail_ff + QCW'(1);
            status_in = zost_pkg::STS_QUEUED;
            state_in  = zost_pkg::ST_RESP;
         end

         zost_pkg::ST_SCAN_INIT: begin
            chain_op = zost_pkg::CH_SCAN_INIT;
            // capture the id to put back for a change by position
            if (by_pos_ff) begin
               id_in = sel_id;
            end
            step_in  = '0;
            state_in = zost_pkg::ST_SCAN_STEP;
         end

         zost_pkg::ST_SCAN_STEP: begin
            chain_op = zost_pkg::CH_SCAN_STEP;
            step_in  = step_ff + SW'(1);
            if (step_ff == SW'(STEPS - 1)) begin
               state_in = zost_pkg::ST_APPLY;
            end
         end

         zost_pkg::ST_APPLY: begin
            if (!row_scan.found) begin
               if (!replay_ff) begin
                  status_in = zost_pkg::STS_NOTFOUND;
               end
               state_in = done_state;
            end else if (op_kind_ff == zost_pkg::KIND_DEL) begin
               chain_op = zost_pkg::CH_DELETE;
               count_in = count_ff - CW'(1);
               state_in = done_state;
            end else if (row_scan.eq) begin
               // unchanged key: the entry stays where it is
               state_in = done_state;
            end else begin
               chain_op = zost_pkg::CH_DELETE;
               count_in = count_ff - CW'(1);
               state_in = zost_pkg::ST_INSERT;
            end
         end

         zost_pkg::ST_INSERT: begin
            chain_op = zost_pkg::CH_INSERT;
            count_in = count_ff + CW'(1);
            state_in = done_state;
         end

         zost_pkg::ST_RP_READ: begin
            state_in = zost_pkg::ST_RP_EXEC;
         end

         zost_pkg::ST_RP_EXEC: begin
            op_kind_in = q_rd_entry.kind;
            id_in      = q_rd_entry.id;
            key_in     = q_rd_entry.key;
            by_pos_in  = 1'b0;
            unique case (q_rd_entry.kind)
               zost_pkg::KIND_ADD: begin
                  state_in = table_full ? zost_pkg::ST_RP_NEXT : zost_pkg::ST_INSERT;
               end
               zost_pkg::KIND_DEL, zost_pkg::KIND_CHG: begin
                  state_in = zost_pkg::ST_SCAN_INIT;
               end
               default: begin
                  state_in = zost_pkg::ST_RP_NEXT;
               end
            endcase
         end

         zost_pkg::ST_RP_NEXT: begin
            idx_in = idx_ff + QCW'(1);
            if ((idx_ff + QCW'(1)) == tail_ff) begin
               tail_in   = '0;
               replay_in = 1'b0;
               state_in  = zost_pkg::ST_RESP;
            end else begin
               state_in = zost_pkg::ST_RP_READ;
            end
         end

         zost_pkg::ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               rsp_id_in     = rid_ff;
               rsp_key_in    = rkey_ff;
               rsp_qcount_in = tail_ff;
               state_in      = zost_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = zost_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= zost_pkg::ST_IDLE;
         count_ff     <= '0;
         tail_ff      <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         lock_ff      <= 1'b0;
         replay_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tail_ff      <= tail_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         lock_ff      <= lock_in;
         replay_ff    <= replay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_kind_ff    <= op_kind_in;
      by_pos_ff     <= by_pos_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      rid_ff        <= rid_in;
      rkey_ff       <= rkey_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_qcount_ff <= rsp_qcount_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_out_id       = rsp_id_ff;
   assign rsp_out_z        = rsp_key_ff;
   assign rsp_queued_count = rsp_qcount_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   logic sorted_ok;

   always_comb begin
      sorted_ok = 1'b1;
      for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
         if (cell_valid[j+1] &&
             ($signed(cell_data[j].key) > $signed(cell_data[j+1].key))) begin
            sorted_ok = 1'b0;
         end
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(TABLE_DEPTH)) && (tail_ff <= QCW'(QUEUE_DEPTH)))
      else $error("entry or queue count beyond its depth");

   a_row_sorted : assert property (@(posedge clock) disable iff (reset)
      (state_ff == zost_pkg::ST_IDLE) |-> sorted_ok)
      else $error("row of cells out of key order");

   a_pos_found : assert property (@(posedge clock) disable iff (reset)
      (state_ff == zost_pkg::ST_APPLY && by_pos_ff) |-> row_scan.found)
      else $error("scan by position found no cell");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      (state_ff == zost_pkg::ST_INSERT) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the table");

   a_rsp_from_resp : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == zost_pkg::ST_RESP))
      else $error("response raised outside the response state");

endmodule

// ===== rtl/core/zost_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the deferred action queue; depends on nothing.
module zost_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/zost_cell.sv =====
// One cell of the sorted row: holds one entry and one scan value.
// Uses zost_pkg types; neighbors are wired by the top level.
module zost_cell #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  zost_pkg::cell_cmd_type cmd,
   input  logic                   valid,
   input  zost_pkg::link_type     left,
   input  logic                   left_le,
   input  zost_pkg::link_type     right,
   input  zost_pkg::scan_type     far,
   output zost_pkg::link_type     data,
   output logic                   le,
   output zost_pkg::scan_type     scan
);

   zost_pkg::link_type data_ff;
   zost_pkg::link_type data_in;
   zost_pkg::scan_type scan_ff;
   zost_pkg::scan_type scan_in;
   logic               match;

   assign match = valid && (cmd.by_pos ? (int'(cmd.pos) == IDX) : (data_ff.id == cmd.id));
   assign le    = valid && ($signed(data_ff.key) <= $signed(cmd.key));

   always_comb begin
      data_in = data_ff;
      scan_in = scan_ff;
      unique case (cmd.op)
         zost_pkg::CH_HOLD: begin
         end
         zost_pkg::CH_SCAN_INIT: begin
            scan_in.found = match;
            scan_in.eq    = match && (data_ff.key == cmd.key);
         end
         zost_pkg::CH_SCAN_STEP: begin
            // keep the leftmost marked cell
            if (far.found) begin
               scan_in = far;
            end
         end
         zost_pkg::CH_INSERT: begin
            if (!le) begin
               if (left_le) begin
                  data_in.id  = cmd.id;
                  data_in.key = cmd.key;
               end else begin
                  data_in = left;
               end
            end
         end
         zost_pkg::CH_DELETE: begin
            if (scan_ff.found) begin
               data_in = right;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      scan_ff <= scan_in;
   end

   assign data = data_ff;
   assign scan = scan_ff;

endmodule
